### hdl/oiht_pkg.sv
// ----------------------------------------------------------------------------
// oiht_pkg
// Shared types, codes and helpers of the open interval hash tracker.
// ----------------------------------------------------------------------------
package oiht_pkg;

   localparam int TableDepthDefault = 256;
   localparam int MaxProbeDefault   = 16;

   // Operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Slot tags
   localparam logic [1:0] TAG_EMPTY = 2'd0;
   localparam logic [1:0] TAG_TOMB  = 2'd1;
   localparam logic [1:0] TAG_OPEN  = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_DUP       = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_ORPHAN    = 3'd4;
   localparam logic [2:0] ST_BACKWARDS = 3'd5;
   localparam logic [2:0] ST_SHORT     = 3'd6;

   // Register indexes
   localparam logic CSR_CAPACITY     = 1'b0;
   localparam logic CSR_MIN_DURATION = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] token;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] event_token;
      logic [63:0] event_time;
      logic [63:0] start_time;
      logic [63:0] duration;
      logic [8:0]  incomplete_count;
      logic [8:0]  open_intervals;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  tag;
      logic [63:0] token;
      logic [63:0] start;
   } slot_type;

   // Four restoring steps of a remainder by cap, most significant bit first.
   function automatic logic [8:0] mod_step(input logic [8:0] rem, input logic [3:0] bits,
                                           input logic [8:0] cap);
      logic [9:0] r;
      r = {1'b0, rem};
      for (int k = 3; k >= 0; k--) begin
         r = {r[8:0], bits[k]};
         if (r >= {1'b0, cap}) begin
            r = r - {1'b0, cap};
         end
      end
      return r[8:0];
   endfunction

endpackage

### hdl/oiht_ram.sv
// ----------------------------------------------------------------------------
// oiht_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module oiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/open_interval_hash_tracker.sv
// ----------------------------------------------------------------------------
// open_interval_hash_tracker
// Keeps open intervals keyed by thread token in a linear-probed hash table.
// ----------------------------------------------------------------------------
// After reset the block empties each of its min(TABLE_DEPTH, 511) slots before
// it takes its first request beat. A start or finish first reduces the mixed
// token modulo the capacity (four remainder bits a cycle), then does a memory
// read and a check for each probed slot, up to min(capacity, MAX_PROBE)
// probes, before it forms its response. A table reset sweeps every slot at
// one a cycle. One request is worked on at a time; the next beat is taken
// while a response still waits in the output register.
module open_interval_hash_tracker
   import oiht_pkg::*;
#(
   parameter int TABLE_DEPTH = oiht_pkg::TableDepthDefault,
   parameter int MAX_PROBE   = oiht_pkg::MaxProbeDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oiht_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oiht_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [63:0]       csr_data
);

   // Slots beyond 510 can never be reached with a nine-bit capacity.
   localparam int SLOTS = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [8:0]    CAP_MAX   = 9'(SLOTS);
   localparam logic [8:0]    PROBE_MAX = 9'(MAX_PROBE);
   localparam logic [AW-1:0] LAST_IDX  = AW'(SLOTS - 1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_HASH  = 9'b000000100,
      S_READ  = 9'b000001000,
      S_CHECK = 9'b000010000,
      S_FIN   = 9'b000100000,
      S_SWEEP = 9'b001000000,
      S_TAIL  = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [8:0]  capacity_ff, capacity_in;
   logic [63:0] min_dur_ff, min_dur_in;
   logic [8:0]  open_ff, open_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        pend_ff, pend_in;
   logic [AW-1:0] idx_ff, idx_in;

   req_type     req_ff, req_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic [63:0] mix_ff, mix_in;
   logic [8:0]  rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [8:0]  slot_ff, slot_in;
   logic [8:0]  probe_ff, probe_in;
   logic [8:0]  count_ff, count_in;
   logic        back_ff, back_in;
   logic [63:0] dur_ff, dur_in;
   logic [63:0] st_ff, st_in;

   logic [8:0]  cap;
   logic [8:0]  limit;
   logic [8:0]  slot_next;
   logic [8:0]  probe_next;
   logic        tok_bad;
   logic [8:0]  rem_step;

   logic        wr_en;
   logic [AW-1:0] wr_addr;
   slot_type    wr_data;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   slot_type    rd_data;

   oiht_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cap        = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign limit      = (cap < PROBE_MAX) ? cap : PROBE_MAX;
   assign slot_next  = (slot_ff + 9'd1 == cap) ? 9'd0 : slot_ff + 9'd1;
   assign probe_next = probe_ff + 9'd1;
   assign rem_step   = mod_step(rem_ff, mix_ff[63:60], cap);
   assign tok_bad    = (req_payload.token == 64'd0) || (req_payload.token[63:1] == '1)
                       || (req_payload.timestamp == 64'd0);

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      capacity_in  = capacity_ff;
      min_dur_in   = min_dur_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      pend_in      = 1'b0;
      idx_in       = idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      mix_in       = mix_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      count_in     = count_ff;
      back_in      = back_ff;
      dur_in       = dur_ff;
      st_in        = st_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(slot_ff);
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = AW'(slot_ff);

      if (csr_valid) begin
         if (csr_index == CSR_CAPACITY) begin
            capacity_in = csr_data[8:0];
         end else begin
            min_dur_in = csr_data;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            idx_in  = idx_ff + AW'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               res_in   = '0;
               mix_in   = req_payload.token ^ (req_payload.token >> 33)
                          ^ (req_payload.token << 11);
               rem_in   = 9'd0;
               cnt_in   = 4'd0;
               probe_in = 9'd0;
               count_in = 9'd0;
               idx_in   = '0;
               if (cap == 9'd0 || req_payload.op == OP_NONE) begin
                  res_in.status = ST_INVALID;
                  state_in      = S_RESP;
               end else if (req_payload.op == OP_RESET) begin
                  state_in = S_SWEEP;
               end else if (tok_bad) begin
                  res_in.status = ST_INVALID;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            rem_in = rem_step;
            mix_in = mix_ff << 4;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               slot_in  = rem_step;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            slot_in  = slot_next;
            probe_in = probe_next;
            state_in = S_READ;
            if (req_ff.op == OP_START) begin
               if (rd_data.tag == TAG_OPEN) begin
                  if (rd_data.token == req_ff.token) begin
                     res_in.status = ST_DUP;
                     state_in      = S_RESP;
                  end else if (probe_next == limit) begin
                     res_in.status = ST_FULL;
                     state_in      = S_RESP;
                  end
               end else begin
                  wr_en         = 1'b1;
                  wr_data.tag   = TAG_OPEN;
                  wr_data.token = req_ff.token;
                  wr_data.start = req_ff.timestamp;
                  open_in       = open_ff + 9'd1;
                  res_in.status = ST_OK;
                  state_in      = S_RESP;
               end
            end else begin
               if (rd_data.tag == TAG_EMPTY) begin
                  res_in.status = ST_ORPHAN;
                  state_in      = S_RESP;
               end else if (rd_data.tag == TAG_OPEN && rd_data.token == req_ff.token) begin
                  wr_en         = 1'b1;
                  wr_data.tag   = TAG_TOMB;
                  wr_data.token = rd_data.token;
                  wr_data.start = 64'd0;
                  if (open_ff != 9'd0) begin
                     open_in = open_ff - 9'd1;
                  end
                  st_in    = rd_data.start;
                  back_in  = req_ff.timestamp < rd_data.start;
                  dur_in   = req_ff.timestamp - rd_data.start;
                  state_in = S_FIN;
               end else if (probe_next == limit) begin
                  res_in.status = ST_ORPHAN;
                  state_in      = S_RESP;
               end
            end
         end
         S_FIN: begin
            if (back_ff) begin
               res_in.status = ST_BACKWARDS;
            end else if (dur_ff < min_dur_ff) begin
               res_in.status = ST_SHORT;
            end else begin
               res_in.status      = ST_OK;
               res_in.event_token = req_ff.token;
               res_in.event_time  = req_ff.timestamp;
               res_in.start_time  = st_ff;
               res_in.duration    = dur_ff;
            end
            state_in = S_RESP;
         end
         S_SWEEP: begin
            // Each slot is read and emptied in the same cycle; its old tag is
            // counted in the next cycle.
            rd_en   = 1'b1;
            rd_addr = idx_ff;
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            pend_in = 1'b1;
            idx_in  = idx_ff + AW'(1);
            if (pend_ff && rd_data.tag == TAG_OPEN) begin
               count_in = count_ff + 9'd1;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (pend_ff && rd_data.tag == TAG_OPEN) begin
               count_in = count_ff + 9'd1;
               res_in.incomplete_count = count_ff + 9'd1;
            end else begin
               res_in.incomplete_count = count_ff;
            end
            res_in.status = ST_OK;
            open_in       = 9'd0;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in                = res_ff;
               rsp_in.open_intervals = open_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         capacity_ff  <= 9'd256;
         min_dur_ff   <= 64'd0;
         open_ff      <= 9'd0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         min_dur_ff   <= min_dur_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      mix_ff   <= mix_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      count_ff <= count_in;
      back_ff  <= back_in;
      dur_ff   <= dur_in;
      st_ff    <= st_in;
   end

endmodule

### tb/sv/tb_oiht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oiht_checker
// Watches the request, response and register channels of the interval
// tracker, keeps its own copy of the slot table and compares every response.
// ----------------------------------------------------------------------------
module tb_oiht_checker
   import oiht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_index,
   input  logic [63:0] csr_data,
   output int      error_count,
   output int      pending_count
);

   localparam int Depth = 256;
   localparam int Probe = 16;

   logic [1:0]  tag_mirror [Depth];
   logic [63:0] token_mirror [Depth];
   logic [63:0] start_mirror [Depth];
   logic [8:0]  open_mirror;
   logic [8:0]  capacity_reg;
   logic [63:0] min_duration_reg;
   rsp_type     expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic rsp_type track_interval(input req_type rq);
      rsp_type r;
      int cap, lim, home, s, n;
      logic [63:0] t, mixed, dur, st;
      logic done;
      r = '0;
      cap = (capacity_reg > Depth) ? Depth : capacity_reg;
      t = rq.token;
      r.status = ST_OK;
      if (cap == 0 || rq.op == OP_NONE) begin
         r.status = ST_INVALID;
      end else if (rq.op == OP_RESET) begin
         n = 0;
         for (int i = 0; i < Depth; i++) begin
            if (tag_mirror[i] == TAG_OPEN) n++;
            tag_mirror[i] = TAG_EMPTY;
         end
         r.incomplete_count = 9'(n);
         open_mirror = 0;
      end else if (t == 0 || t >= 64'hFFFF_FFFF_FFFF_FFFE || rq.timestamp == 0) begin
         r.status = ST_INVALID;
      end else begin
         mixed = t ^ (t >> 33) ^ (t << 11);
         home = int'(mixed % 64'(cap));
         lim = (cap < Probe) ? cap : Probe;
         done = 1'b0;
         r.status = (rq.op == OP_START) ? ST_FULL : ST_ORPHAN;
         for (int p = 0; p < lim && !done; p++) begin
            s = (home + p) % cap;
            if (rq.op == OP_START) begin
               if (tag_mirror[s] == TAG_OPEN) begin
                  if (token_mirror[s] == t) begin
                     r.status = ST_DUP;
                     done = 1'b1;
                  end
               end else begin
                  tag_mirror[s] = TAG_OPEN;
                  token_mirror[s] = t;
                  start_mirror[s] = rq.timestamp;
                  open_mirror++;
                  r.status = ST_OK;
                  done = 1'b1;
               end
            end else if (tag_mirror[s] == TAG_EMPTY) begin
               done = 1'b1;
            end else if (tag_mirror[s] == TAG_OPEN && token_mirror[s] == t) begin
               done = 1'b1;
               st = start_mirror[s];
               tag_mirror[s] = TAG_TOMB;
               if (open_mirror > 0) open_mirror--;
               dur = rq.timestamp - st;
               if (rq.timestamp < st) r.status = ST_BACKWARDS;
               else if (dur < min_duration_reg) r.status = ST_SHORT;
               else begin
                  r.status = ST_OK;
                  r.event_token = t;
                  r.event_time = rq.timestamp;
                  r.start_time = st;
                  r.duration = dur;
               end
            end
         end
      end
      r.open_intervals = open_mirror;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < Depth; i++) tag_mirror[i] = TAG_EMPTY;
         open_mirror = 0;
         capacity_reg = 9'd256;
         min_duration_reg = '0;
         error_count = 0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CAPACITY) capacity_reg = csr_data[8:0];
            else min_duration_reg = csr_data;
         end
         if (req_valid && req_ready) expected_rsp.push_back(track_interval(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp_payload);
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.status != rsp_payload.status || want.event_token != rsp_payload.event_token
                   || want.event_time != rsp_payload.event_time
                   || want.start_time != rsp_payload.start_time
                   || want.duration != rsp_payload.duration
                   || want.incomplete_count != rsp_payload.incomplete_count
                   || want.open_intervals != rsp_payload.open_intervals) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_payload);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb_open_interval_hash_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_interval_hash_tracker
// Drives directed and random interval traffic into the tracker under several
// capacity and minimum-duration settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_open_interval_hash_tracker;
   import oiht_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = 1'b0;
   logic [63:0] csr_data = '0;
   int      error_count;
   int      pending_count;
   int      stall_pct = 27;
   logic    hold_go = 1'b0;
   logic    hold_seen = 1'b0;
   int      hold_off = 0;
   logic [63:0] token_pool [16];
   logic [63:0] clock_ns = 64'd1000;

   always #1 clock = ~clock;

   open_interval_hash_tracker dut (.*);

   tb_oiht_checker checker_i (.*);

   initial begin
      #4000000;
      $display("tb_open_interval_hash_tracker NOT OK");
      $finish;
   end

   // Receiver: random stalls plus one long hold-off once it is asked for.
   always @(negedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Leaves valid high after the beat; the next call or drain replaces it.
   task automatic send_req(input logic [1:0] op, input logic [63:0] tok,
                           input logic [63:0] ts);
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: op, token: tok, timestamp: ts};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for every response, then covers a full table sweep.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      int k;
      logic [1:0] op;
      logic [63:0] tok, ts;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         clock_ns = clock_ns + 64'($urandom_range(200));
         ts = clock_ns;
         tok = token_pool[4'($urandom_range(15))];
         op = (k < 48) ? OP_START : (k < 94) ? OP_FINISH : (k < 97) ? OP_RESET : OP_NONE;
         if (k % 11 == 0) tok = {$urandom, $urandom};
         if (k % 29 == 0) ts = {$urandom, $urandom};
         if (k % 37 == 0) ts = clock_ns - 64'd5000;
         send_req(op, tok, ts);
      end
   endtask

   initial begin
      int caps [5] = '{256, 1, 17, 511, 5};
      logic [63:0] mins [5] = '{64'd0, 64'd50, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd100};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) token_pool[i] = {$urandom, $urandom} | 64'd1;
      token_pool[0] = 64'd1;
      token_pool[1] = 64'hFFFF_FFFF_FFFF_FFFD;
      // Directed part.
      send_req(OP_START, 64'd0, 64'd5);
      send_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFE, 64'd5);
      send_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
      send_req(OP_START, 64'd1, 64'd0);
      send_req(OP_START, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_START, 64'd1, 64'd7);
      send_req(OP_FINISH, 64'd1, 64'd3);
      send_req(OP_FINISH, 64'd1, 64'd3);
      send_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFD, 64'd10);
      send_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFD, 64'd11);
      send_req(OP_FINISH, 64'hFFFF_FFFF_FFFF_FFFD, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_NONE, 64'd1, 64'd1);
      send_req(OP_START, 64'd9, 64'd1);
      send_req(OP_RESET, 64'd0, 64'd0);
      drain();
      write_reg(CSR_CAPACITY, 64'd2);
      write_reg(CSR_MIN_DURATION, 64'd10);
      for (int i = 2; i < 6; i++) send_req(OP_START, 64'(i), 64'd100);
      send_req(OP_FINISH, 64'd2, 64'd105);
      send_req(OP_FINISH, 64'd3, 64'd200);
      drain();
      write_reg(CSR_CAPACITY, 64'd0);
      send_req(OP_START, 64'd7, 64'd1);
      send_req(OP_RESET, 64'd0, 64'd0);
      drain();
      // Long receiver hold-off while requests keep coming.
      write_reg(CSR_CAPACITY, 64'd256);
      hold_go = 1'b1;
      random_phase(30);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_CAPACITY, 64'(caps[ph]));
         write_reg(CSR_MIN_DURATION, mins[ph]);
         stall_pct = (ph == 3) ? 0 : 27;
         random_phase(330);
         drain();
      end
      if (error_count == 0) $display("tb_open_interval_hash_tracker OK");
      else $display("tb_open_interval_hash_tracker NOT OK");
      $finish;
   end

endmodule
